// File: rtl/tmsf_pkg.sv
package tmsf_pkg;

  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned STORE_BYTES = HDR_BYTES - 1;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [31:0] TYPE_LOW    = 32'd1;
  localparam logic [31:0] TYPE_HIGH   = 32'd4;
  localparam logic [7:0]  SLACK_RESET = 8'd2;

  // One queued word: a whole header, or a single payload byte in hdr[0].
  typedef struct packed {
    logic                           is_hdr;
    logic                           last;
    logic [HDR_BYTES-1:0][7:0]      hdr;
  } q_entry_t;

endpackage

// File: rtl/timed_message_stream_filter_core.sv
// Timed message stream filter.
// Input channel (in_valid/in_ready/in_byte) takes one raw byte a word of a
// stream of messages: 12-byte header (type, time, length, little-endian
// 32-bit) then length payload bytes. Output channel (out_valid/out_ready/
// out_byte/out_last) gives the header and payload of each passed message;
// out_last flags its final byte. cfg_wr_en/cfg_wr_data write time_slack.
// Input accepts one word a cycle while the queue has room; the 12th header
// byte of a passed message queues the whole header, which leaves one byte
// per cycle while out_ready is high, so sustained rate is one word per cycle.
// When the queue is empty, a queued entry is output the cycle after its push.
// A stalled receiver holds out_* steady; once the FIFO_DEPTH-entry queue
// fills, in_ready drops until the receiver drains it.
// Synchronous reset clears the queue, counters, maximum time and sets
// time_slack to 2; partial headers are forgotten.
module timed_message_stream_filter_core #(
  parameter int unsigned FIFO_DEPTH = tmsf_pkg::FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import tmsf_pkg::*;

  q_entry_t push_data, head;
  logic     push, pop, full, empty;

  tmsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  tmsf_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  tmsf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (empty),
    .q_head   (head),
    .q_pop    (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule

// File: rtl/tmsf_front.sv
module tmsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  input  logic              q_full,
  output logic              q_push,
  output tmsf_pkg::q_entry_t q_data
);
  import tmsf_pkg::*;

  logic [7:0]  slack_r;
  logic [3:0]  hcount_r, hcount_nxt;
  logic [7:0]  store_r [STORE_BYTES];
  logic [31:0] left_r, left_nxt;
  logic        in_pay_r, in_pay_nxt;
  logic        fwd_r, fwd_nxt;
  logic [31:0] max_r, max_nxt;

  logic                      acc;
  logic [HDR_BYTES-1:0][7:0] hdr;
  logic [HDR_BYTES*8-1:0]    hdr_flat;
  logic [31:0]               typ, tm, len, tm_sl;
  logic                      pass, pay_last, hdr_done;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      hdr[i] = store_r[i];
    end
    hdr[HDR_BYTES-1] = in_byte;
  end

  assign hdr_flat = hdr;
  assign typ      = hdr_flat[31:0];
  assign tm       = hdr_flat[63:32];
  assign len      = hdr_flat[95:64];
  assign tm_sl    = tm + {24'd0, slack_r};
  assign pass     = (typ >= TYPE_LOW) && (typ <= TYPE_HIGH) && (tm_sl > max_r);
  assign pay_last = (left_r <= 32'd1);
  assign hdr_done = (hcount_r == 4'(STORE_BYTES));

  always_comb begin
    hcount_nxt = hcount_r;
    left_nxt   = left_r;
    in_pay_nxt = in_pay_r;
    fwd_nxt    = fwd_r;
    max_nxt    = max_r;
    q_push     = 1'b0;
    q_data     = '0;
    if (acc) begin
      if (in_pay_r) begin
        q_push          = fwd_r;
        q_data.is_hdr   = 1'b0;
        q_data.last     = pay_last;
        q_data.hdr[0]   = in_byte;
        left_nxt        = pay_last ? 32'd0 : left_r - 32'd1;
        if (pay_last) begin
          in_pay_nxt = 1'b0;
          fwd_nxt    = 1'b0;
        end
      end else if (!hdr_done) begin
        hcount_nxt = hcount_r + 4'd1;
      end else begin
        hcount_nxt = '0;
        if (len != 32'd0) begin
          in_pay_nxt = 1'b1;
          left_nxt   = len;
          fwd_nxt    = pass;
        end
        if (pass) begin
          q_push        = 1'b1;
          q_data.is_hdr = 1'b1;
          q_data.last   = (len == 32'd0);
          q_data.hdr    = hdr;
          if (tm > max_r) begin
            max_nxt = tm;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slack_r  <= SLACK_RESET;
      hcount_r <= '0;
      left_r   <= '0;
      in_pay_r <= 1'b0;
      fwd_r    <= 1'b0;
      max_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        slack_r <= cfg_wr_data;
      end
      hcount_r <= hcount_nxt;
      left_r   <= left_nxt;
      in_pay_r <= in_pay_nxt;
      fwd_r    <= fwd_nxt;
      max_r    <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !in_pay_r && !hdr_done) begin
      store_r[hcount_r] <= in_byte;
    end
  end

endmodule

// File: rtl/tmsf_fifo.sv
module tmsf_fifo #(
  parameter int unsigned DEPTH = tmsf_pkg::FIFO_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tmsf_pkg::q_entry_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output tmsf_pkg::q_entry_t head
);
  import tmsf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (do_pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

// File: rtl/tmsf_back.sv
module tmsf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  tmsf_pkg::q_entry_t q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import tmsf_pkg::*;

  logic [3:0] idx_r;
  logic       acc, hdr_end;

  assign out_valid = !q_empty;
  assign acc       = out_valid && out_ready;
  assign hdr_end   = (idx_r == 4'(HDR_BYTES - 1));
  assign out_byte  = q_head.is_hdr ? q_head.hdr[idx_r] : q_head.hdr[0];
  assign out_last  = q_head.is_hdr ? (hdr_end && q_head.last) : q_head.last;
  assign q_pop     = acc && (!q_head.is_hdr || hdr_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (acc && q_head.is_hdr) begin
      idx_r <= hdr_end ? '0 : idx_r + 4'd1;
    end
  end

endmodule

// File: rtl/tmsf_checker.sv
module tmsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid)
    else $error("input stalled with nothing queued");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output word without input word");

endmodule

bind timed_message_stream_filter_core tmsf_checker u_chk (.*);

// File: bench/timed_message_stream_filter_tb_pkg.sv
package timed_message_stream_filter_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import tmsf_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } out_word_t;

  // Tracks the filter state and holds the words the block owes the receiver.
  class filter_scoreboard;
    logic [7:0]  slack;
    logic [3:0]  hdr_count;
    logic [7:0]  hdr_bytes [STORE_BYTES];
    logic [31:0] bytes_left;
    bit          in_body;
    bit          passing;
    logic [31:0] max_time;
    out_word_t   pending [$];
    int          errors;
    int          words_checked;
    int          passed_msgs;
    int          dropped_msgs;

    function new();
      slack         = SLACK_RESET;
      hdr_count     = '0;
      bytes_left    = '0;
      in_body       = 1'b0;
      passing       = 1'b0;
      max_time      = '0;
      errors        = 0;
      words_checked = 0;
      passed_msgs   = 0;
      dropped_msgs  = 0;
    endfunction

    function void set_slack(logic [7:0] v);
      slack = v;
    endfunction

    function void note_byte(logic [7:0] b);
      logic [7:0]  hdr [HDR_BYTES];
      logic [31:0] kind;
      logic [31:0] stamp;
      logic [31:0] len;
      logic [31:0] sum;
      bit          ok;
      bit          body_end;
      out_word_t   w;
      if (in_body) begin
        body_end = (bytes_left <= 32'd1);
        if (passing) begin
          w.data    = b;
          w.is_last = body_end;
          pending.push_back(w);
        end
        bytes_left = body_end ? 32'd0 : bytes_left - 32'd1;
        if (body_end) begin
          in_body = 1'b0;
          passing = 1'b0;
        end
        return;
      end
      if (hdr_count < STORE_BYTES) begin
        hdr_bytes[hdr_count] = b;
        hdr_count++;
        return;
      end
      for (int i = 0; i < STORE_BYTES; i++) hdr[i] = hdr_bytes[i];
      hdr[HDR_BYTES-1] = b;
      hdr_count = '0;
      kind  = {hdr[3], hdr[2], hdr[1], hdr[0]};
      stamp = {hdr[7], hdr[6], hdr[5], hdr[4]};
      len   = {hdr[11], hdr[10], hdr[9], hdr[8]};
      sum   = stamp + {24'd0, slack};
      ok    = (kind >= TYPE_LOW) && (kind <= TYPE_HIGH) && (sum > max_time);
      if (len != 32'd0) begin
        in_body    = 1'b1;
        bytes_left = len;
        passing    = ok;
      end
      if (!ok) begin
        dropped_msgs++;
        return;
      end
      passed_msgs++;
      if (stamp > max_time) max_time = stamp;
      for (int i = 0; i < HDR_BYTES; i++) begin
        w.data    = hdr[i];
        w.is_last = (i == HDR_BYTES - 1) && (len == 32'd0);
        pending.push_back(w);
      end
    endfunction

    function void check_word(logic [7:0] b, logic l);
      out_word_t w;
      words_checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %02h last %0b", $time, b, l);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (b !== w.data) begin
        $display("%0t: out_byte expected %02h got %02h", $time, w.data, b);
        errors++;
      end
      if (l !== w.is_last) begin
        $display("%0t: out_last expected %0b got %0b", $time, w.is_last, l);
        errors++;
      end
    endfunction

    function void report_leftovers();
      out_word_t w;
      while (pending.size() != 0) begin
        w = pending.pop_front();
        $display("%0t: missing word expected %02h last %0b", $time, w.data, w.is_last);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: bench/timed_message_stream_filter_core_tb.sv
module timed_message_stream_filter_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tmsf_pkg::*;
  import timed_message_stream_filter_tb_pkg::*;

  localparam int          SETTLE      = 16;
  localparam int          DRAIN_LIMIT = 20000;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_LEN    = 120;
  localparam int          PHASE_BYTES = 14;

  logic       clk;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte     = 8'd0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_wr_en   = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int unsigned hold_cycles  = 0;
  int          bytes_sent   = 0;
  int          cycle_count  = 0;

  filter_scoreboard board;

  timed_message_stream_filter_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL timed_message_stream_filter_core");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready   <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_word(out_byte, out_last);
  end

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (!in_ready);
    board.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_message(input logic [31:0] kind, input logic [31:0] stamp,
                              input logic [31:0] len);
    logic [95:0] hdr;
    hdr = {len, stamp, kind};
    for (int i = 0; i < HDR_BYTES; i++) send_byte(hdr[8*i +: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_message();
    logic [31:0] kind;
    logic [31:0] stamp;
    logic [31:0] len;
    logic [31:0] top;
    int unsigned pick;
    int unsigned off;
    pick = $urandom_range(0, 99);
    if (pick < 70)      kind = $urandom_range(TYPE_LOW, TYPE_HIGH);
    else if (pick < 80) kind = TYPE_LOW - 1;
    else if (pick < 90) kind = TYPE_HIGH + 1;
    else                kind = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // time plus slack lands just around the running maximum
      off = $urandom_range(0, 4);
      top = board.max_time + off;
      if (top >= {24'd0, board.slack} + 32'd2) stamp = top - 32'd2 - {24'd0, board.slack};
      else stamp = off;
    end else if (pick < 85) begin
      stamp = board.max_time + $urandom_range(1, 20);
    end else if (kind < TYPE_LOW || kind > TYPE_HIGH) begin
      stamp = $urandom;
    end else begin
      off   = $urandom_range(0, 100);
      stamp = (board.max_time > off) ? board.max_time - off : 32'd0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60)      len = $urandom_range(0, 3);
    else if (pick < 92) len = $urandom_range(4, 12);
    else                len = $urandom_range(13, 30);
    send_message(kind, stamp, len);
  endtask

  task automatic run_random(input int n);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n) random_message();
  endtask

  task automatic wait_drained();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slack(input logic [7:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.set_slack(v);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] mid_slack;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset slack; zero length passes, then a time that only fails by wrapping
    send_message(TYPE_LOW, 32'd5, 32'd0);
    send_message(TYPE_HIGH, 32'hFFFF_FFFF, 32'd1);
    wait_drained();

    write_slack(8'd0);
    hold_cycles <= HOLD_LEN;
    repeat (2) send_message(TYPE_LOW, board.max_time + 32'd1, 32'd6);
    run_random(PHASE_BYTES);
    wait_drained();

    write_slack(8'd255);
    tx_idle_pct = 48;
    run_random(PHASE_BYTES);
    wait_drained();

    mid_slack = 8'($urandom_range(1, 254));
    write_slack(mid_slack);
    tx_idle_pct  = 0;
    rx_stall_pct = 48;
    run_random(PHASE_BYTES);
    wait_drained();

    write_slack(SLACK_RESET);
    tx_idle_pct  = 22;
    rx_stall_pct = 22;
    run_random(PHASE_BYTES);
    // stream ends inside a header
    for (int i = 0; i < 7; i++) send_byte(8'($urandom_range(0, 255)));
    wait_drained();

    board.report_leftovers();
    $display("Checked %0d output words from %0d input bytes: %0d passed, %0d dropped.",
             board.words_checked, bytes_sent, board.passed_msgs, board.dropped_msgs);
    $display("Slack 2, 0, 255, %0d and 2; idle mixes none, sender, receiver, both;",
             mid_slack);
    $display("one long receiver hold-off filled the queue.");
    if (board.errors == 0) begin
      $display("PASS timed_message_stream_filter_core");
    end else begin
      $display("FAIL timed_message_stream_filter_core");
    end
    $finish;
  end

endmodule
